/* rtl/asp_pkg.sv */
// ----------------------------------------------------------------------------
// asp_pkg
// shared types, widths and the entry ordering rule for the anchor suppressor
// ----------------------------------------------------------------------------
package asp_pkg;

  localparam int unsigned THR_W     = 24;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned TDATA_W   = 112;

  // first member is the most significant, so read_id sits in the low bits
  typedef struct packed {
    logic [POS_W-1:0]  qry_pos;
    logic [POS_W-1:0]  ref_pos;
    logic signed [15:0] score;
    logic [9:0]        chrom_id;
    logic [15:0]       read_id;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // true when a must be placed strictly ahead of b
  function automatic logic goes_before(entry_t a, entry_t b);
    logic res;
    if (a.read_id != b.read_id) begin
      res = a.read_id < b.read_id;
    end else if (a.score != b.score) begin
      res = a.score > b.score;
    end else if (a.ref_pos != b.ref_pos) begin
      res = a.ref_pos < b.ref_pos;
    end else begin
      res = a.qry_pos < b.qry_pos;
    end
    return res;
  endfunction

endpackage

/* rtl/asp_ram.sv */
// ----------------------------------------------------------------------------
// asp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module asp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/asp_slope.sv */
// ----------------------------------------------------------------------------
// asp_slope
// shared slope test: |dr - dq| * 2^16 <= thr * |dq|, three register stages
// ----------------------------------------------------------------------------
module asp_slope (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [asp_pkg::POS_W-1:0]    a_ref,
  input  logic [asp_pkg::POS_W-1:0]    a_query,
  input  logic [asp_pkg::POS_W-1:0]    b_ref,
  input  logic [asp_pkg::POS_W-1:0]    b_query,
  input  logic [asp_pkg::THR_W-1:0]    thr,
  output logic                         done,
  output logic                         close
);

  localparam int unsigned PW  = asp_pkg::POS_W;
  localparam int unsigned NW  = PW + 1 + asp_pkg::FRAC_BITS;
  localparam int unsigned DW  = PW + asp_pkg::THR_W;

  logic signed [PW:0]   dr, dq;
  logic signed [PW+1:0] dd;

  logic          s1_vld_r, s2_vld_r, s3_vld_r;
  logic [PW:0]   s1_absd_r;
  logic [PW-1:0] s1_absq_r;
  logic          s1_zero_r, s2_zero_r;
  logic [NW-1:0] s2_num_r;
  logic [DW-1:0] s2_den_r;
  logic          s3_close_r;

  assign dr = $signed({1'b0, a_ref}) - $signed({1'b0, b_ref});
  assign dq = $signed({1'b0, a_query}) - $signed({1'b0, b_query});
  assign dd = {dr[PW], dr} - {dq[PW], dq};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
    s1_absd_r  <= dd[PW+1] ? (PW+1)'(0) - dd[PW:0] : dd[PW:0];
    s1_absq_r  <= dq[PW] ? PW'(0) - dq[PW-1:0] : dq[PW-1:0];
    s1_zero_r  <= dq == '0;
    s2_num_r   <= {s1_absd_r, {asp_pkg::FRAC_BITS{1'b0}}};
    s2_den_r   <= DW'(thr) * DW'(s1_absq_r);
    s2_zero_r  <= s1_zero_r;
    s3_close_r <= !s2_zero_r && (DW'(s2_num_r) <= s2_den_r);
  end

  assign done  = s3_vld_r;
  assign close = s3_close_r;

endmodule

/* rtl/anchor_slope_suppression.sv */
// ----------------------------------------------------------------------------
// anchor_slope_suppression
// sorted burst store of alignment locations with greedy slope suppression
// ----------------------------------------------------------------------------
// in_*: one location per transfer, in_tlast marks the end of the burst.
// cfg_wr_en/cfg_wr_data load the slope threshold (16 fraction bits).
// out_*: kept locations in sorted order, out_tuser is the overflow flag,
// out_tlast marks the final kept location of the burst.
// a location is placed by insertion into ram: after its transfer, each
// entry that sorts after it is read, compared and shifted up by one place.
// a location arriving with MAX_ENTRIES already held is dropped.
// after in_tlast the sweep reads each entry, and for each kept one tests
// later entries of the same read through the shared slope unit; in_tready
// stays low until the last kept location has been handed to the output
// register.
// the output register holds a result while out_tready is low, stalling
// the sweep at each kept entry, and at the end, while it is still occupied.
// reset empties the store and clears the threshold; no clearing pass.
// ----------------------------------------------------------------------------
module anchor_slope_suppression #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [asp_pkg::THR_W-1:0]         cfg_wr_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // read_id, chrom_id, align_score, ref_pos, qry_pos, zero pad
  input  logic [asp_pkg::TDATA_W-1:0]       in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_read_id, out_chrom_id, out_score, out_ref_pos, out_qry_pos, zero pad
  output logic [asp_pkg::TDATA_W-1:0]       out_tdata,
  // overflow
  output logic                              out_tuser,
  output logic                              out_tlast
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW = asp_pkg::ENTRY_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INS_RD = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_SW_RDI = 4'd3;
  localparam logic [3:0] S_SW_I   = 4'd4;
  localparam logic [3:0] S_SW_EMIT = 4'd5;
  localparam logic [3:0] S_SW_RDJ = 4'd6;
  localparam logic [3:0] S_SW_J   = 4'd7;
  localparam logic [3:0] S_SW_SLP = 4'd8;
  localparam logic [3:0] S_FLUSH  = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic          last_r, last_nxt;
  logic          ovf_r, ovf_nxt;
  logic [asp_pkg::THR_W-1:0] thr_r;
  asp_pkg::entry_t new_r, new_nxt;
  asp_pkg::entry_t cur_r, cur_nxt;
  asp_pkg::entry_t hold_r, hold_nxt;
  logic            hold_vld_r, hold_vld_nxt;
  asp_pkg::entry_t out_r, out_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic          data_we, flag_we, flag_wdata, flag_rdata;
  logic [AW-1:0] data_waddr, data_raddr, flag_waddr, flag_raddr;
  asp_pkg::entry_t data_wdata, data_rdata;
  logic [EW-1:0] data_rword;
  logic          in_fire, full, out_free, slp_start, slp_done, slp_close;

  assign in_tready = state_r == S_IDLE;
  assign in_fire   = in_tvalid && in_tready;
  assign full      = count_r == CW'(MAX_ENTRIES);
  assign out_free  = !out_vld_r || out_tready;
  assign data_rdata = asp_pkg::entry_t'(data_rword);

  asp_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_data (
    .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
    .raddr(data_raddr), .rdata(data_rword)
  );

  asp_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_flag (
    .clk(clk), .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
    .raddr(flag_raddr), .rdata(flag_rdata)
  );

  asp_slope u_slope (
    .clk(clk), .rst_n(rst_n), .start(slp_start),
    .a_ref(cur_r.ref_pos), .a_query(cur_r.qry_pos),
    .b_ref(data_rdata.ref_pos), .b_query(data_rdata.qry_pos),
    .thr(thr_r), .done(slp_done), .close(slp_close)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    last_nxt     = last_r;
    ovf_nxt      = ovf_r;
    new_nxt      = new_r;
    cur_nxt      = cur_r;
    hold_nxt     = hold_r;
    hold_vld_nxt = hold_vld_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;
    data_we      = 1'b0;
    data_waddr   = pos_r[AW-1:0];
    data_wdata   = new_r;
    data_raddr   = i_r[AW-1:0];
    flag_we      = 1'b0;
    flag_waddr   = j_r[AW-1:0];
    flag_wdata   = 1'b1;
    flag_raddr   = i_r[AW-1:0];
    slp_start    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (full) begin
            ovf_nxt = 1'b1;
            if (in_tlast) begin
              i_nxt        = '0;
              hold_vld_nxt = 1'b0;
              state_nxt    = S_SW_RDI;
            end
          end else begin
            // positions below the count are always freshly cleared
            flag_we    = 1'b1;
            flag_waddr = count_r[AW-1:0];
            flag_wdata = 1'b0;
            new_nxt    = asp_pkg::entry_t'(in_tdata[EW-1:0]);
            last_nxt   = in_tlast;
            pos_nxt    = count_r;
            state_nxt  = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        data_raddr = AW'(pos_r - CW'(1));
        if (pos_r == '0) begin
          data_we   = 1'b1;
          count_nxt = count_r + CW'(1);
          i_nxt        = '0;
          hold_vld_nxt = 1'b0;
          state_nxt = last_r ? S_SW_RDI : S_IDLE;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        data_we = 1'b1;
        if (asp_pkg::goes_before(new_r, data_rdata)) begin
          // shift the held entry up by one
          data_wdata = data_rdata;
          pos_nxt    = pos_r - CW'(1);
          state_nxt  = S_INS_RD;
        end else begin
          count_nxt    = count_r + CW'(1);
          i_nxt        = '0;
          hold_vld_nxt = 1'b0;
          state_nxt    = last_r ? S_SW_RDI : S_IDLE;
        end
      end
      S_SW_RDI: begin
        state_nxt = (i_r == count_r) ? S_FLUSH : S_SW_I;
      end
      S_SW_I: begin
        if (flag_rdata) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SW_RDI;
        end else begin
          cur_nxt   = data_rdata;
          state_nxt = S_SW_EMIT;
        end
      end
      S_SW_EMIT: begin
        // previous kept entry goes out once a later one is known
        if (out_free) begin
          if (hold_vld_r) begin
            out_nxt      = hold_r;
            out_vld_nxt  = 1'b1;
            out_last_nxt = 1'b0;
            out_ovf_nxt  = ovf_r;
          end
          hold_nxt     = cur_r;
          hold_vld_nxt = 1'b1;
          j_nxt        = i_r + CW'(1);
          state_nxt    = S_SW_RDJ;
        end
      end
      S_SW_RDJ: begin
        data_raddr = j_r[AW-1:0];
        flag_raddr = j_r[AW-1:0];
        if (j_r == count_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SW_RDI;
        end else begin
          state_nxt = S_SW_J;
        end
      end
      S_SW_J: begin
        if (flag_rdata) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_SW_RDJ;
        end else if (data_rdata.read_id != cur_r.read_id) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SW_RDI;
        end else begin
          slp_start = 1'b1;
          state_nxt = S_SW_SLP;
        end
      end
      S_SW_SLP: begin
        if (slp_done) begin
          flag_we   = slp_close;
          j_nxt     = j_r + CW'(1);
          state_nxt = S_SW_RDJ;
        end
      end
      S_FLUSH: begin
        if (!out_vld_r) begin
          if (hold_vld_r) begin
            out_nxt      = hold_r;
            out_vld_nxt  = 1'b1;
            out_last_nxt = 1'b1;
            out_ovf_nxt  = ovf_r;
          end
          hold_vld_nxt = 1'b0;
          count_nxt    = '0;
          ovf_nxt      = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      thr_r      <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
    pos_r      <= pos_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    last_r     <= last_nxt;
    new_r      <= new_nxt;
    cur_r      <= cur_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(asp_pkg::TDATA_W - EW)'(0), out_r};
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/asp_checker.sv */
// ----------------------------------------------------------------------------
// asp_checker
// port level checks for the anchor suppressor, bound to the top level
// ----------------------------------------------------------------------------
module asp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        in_tlast,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [asp_pkg::TDATA_W-1:0] out_tdata,
  input logic                        out_tuser,
  input logic                        out_tlast
);

  // nothing offered on the output straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // the end of a burst always starts a sweep
  a_sweep_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("ready straight after burst end");

  // more results still to come keep the input closed
  a_busy_midburst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !in_tready)
    else $error("input opened before final result");

endmodule

bind anchor_slope_suppression asp_checker u_asp_checker (.*);
